// ===== rtl/altitude_pid_throttle_core_defines.svh =====
// ----------------------------------------------------------------------------
// Altitude PID throttle: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_PID_THROTTLE_CORE_DEFINES_SVH
`define ALTITUDE_PID_THROTTLE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define APT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// Altitude PID throttle package
// Widths, reset constants and register indexes shared across the block.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned LimitW = 31;
  localparam int unsigned IndexW = 3;
  localparam int unsigned FracW  = 16;

  // 860.0 in Q16.16
  localparam logic signed [DataW-1:0] ThrottleReset = 32'sd56360960;

  typedef enum logic [IndexW-1:0] {
    REG_TARGET = 3'd0,
    REG_PGAIN  = 3'd1,
    REG_IGAIN  = 3'd2,
    REG_DGAIN  = 3'd3,
    REG_LIMIT  = 3'd4
  } apt_reg_t;

endpackage

// ===== rtl/apt_meas_if.sv =====
// ----------------------------------------------------------------------------
// Altitude sample channel
// Valid/ready channel carrying one measured altitude per transaction.
// ----------------------------------------------------------------------------
interface apt_meas_if;
  logic                               valid;
  logic                               ready;
  logic signed [apt_pkg::DataW-1:0]   measured_altitude;

  modport source (output valid, output measured_altitude, input ready);
  modport sink   (input valid, input measured_altitude, output ready);
endinterface

// ===== rtl/apt_throttle_if.sv =====
// ----------------------------------------------------------------------------
// Throttle result channel
// Valid/ready channel carrying one updated throttle level per transaction.
// ----------------------------------------------------------------------------
interface apt_throttle_if;
  logic                               valid;
  logic                               ready;
  logic signed [apt_pkg::DataW-1:0]   throttle_out;

  modport source (output valid, output throttle_out, input ready);
  modport sink   (input valid, input throttle_out, output ready);
endinterface

// ===== rtl/altitude_pid_throttle_core.sv =====
// ----------------------------------------------------------------------------
// Altitude PID throttle core
// Clamped-integral PID on signed Q16.16 altitude samples, accumulating throttle.
// ----------------------------------------------------------------------------
// Each sample transaction produces exactly one throttle transaction. The path
// is three registered steps: error, clamped error sum and derivative at
// acceptance; the three 32x32 gain products; then the throttle accumulate
// and saturate into the output register. While result.ready holds, a new
// sample is taken every cycle, so throughput is one transaction per cycle;
// the throttle accumulator is the only loop in the last step and sets that
// rate. The user must write configuration through write_enable/reg_index/
// write_data only while the core is idle; the core does not enforce this.
// Unknown indexes are ignored. After reset the throttle level is 860.0.
`include "altitude_pid_throttle_core_defines.svh"

module altitude_pid_throttle_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [apt_pkg::IndexW-1:0]          reg_index,
  input  logic [apt_pkg::DataW-1:0]           write_data,
  apt_meas_if.sink                            sample,
  apt_throttle_if.source                      result
);

  localparam int unsigned W   = apt_pkg::DataW;
  localparam int unsigned PW  = 2 * W;           // product width
  localparam int unsigned TW  = PW - apt_pkg::FracW; // scaled term width
  localparam int unsigned AW  = TW + 2;          // accumulate width

  // configuration
  logic signed [W-1:0]              target_altitude;
  logic signed [W-1:0]              p_gain;
  logic signed [W-1:0]              i_gain;
  logic signed [W-1:0]              d_gain;
  logic [apt_pkg::LimitW-1:0]       integral_limit;

  // controller state
  logic signed [W-1:0]              err_accum;
  logic signed [W-1:0]              previous_error;
  logic signed [W-1:0]              throttle_level;

  // stage A: error terms
  logic                             va;
  logic signed [W-1:0]              err_a;
  logic signed [W-1:0]              sum_a;
  logic signed [W-1:0]              der_a;

  // stage B: products
  logic                             vb;
  logic signed [PW-1:0]             prod_p;
  logic signed [PW-1:0]             prod_i;
  logic signed [PW-1:0]             prod_d;

  logic                             vo;

  logic                             accept;
  logic                             adv_b;
  logic                             adv_o;

  logic signed [W:0]                err_wide;
  logic signed [W-1:0]              err_next;
  logic signed [W:0]                sum_wide;
  logic signed [W:0]                lim_wide;
  logic signed [W-1:0]              sum_next;
  logic signed [W:0]                der_wide;
  logic signed [W-1:0]              der_next;
  logic signed [AW-1:0]             acc;
  logic signed [W-1:0]              throttle_next;

  function automatic logic signed [W-1:0] sat_w1(input logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) begin
      r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] throttle_sat_max();
    return {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [W-1:0] throttle_sat_min();
    return {1'b1, {(W-1){1'b0}}};
  endfunction

  // handshake and stage movement
  assign adv_o        = vb && (!vo || result.ready);
  assign adv_b        = va && (!vb || adv_o);
  assign sample.ready = !va || adv_b;
  assign accept       = sample.valid && sample.ready;

  assign result.valid        = vo;
  assign result.throttle_out = throttle_level;

  // error, clamped sum, derivative
  always_comb begin
    err_wide = {sample.measured_altitude[W-1], sample.measured_altitude}
             - {target_altitude[W-1], target_altitude};
    err_next = sat_w1(err_wide);
    sum_wide = {err_accum[W-1], err_accum} + {err_next[W-1], err_next};
    lim_wide = {2'b00, integral_limit};
    if (sum_wide > lim_wide) begin
      sum_next = lim_wide[W-1:0];
    end else if (sum_wide < -lim_wide) begin
      sum_next = W'(-lim_wide);
    end else begin
      sum_next = sum_wide[W-1:0];
    end
    der_wide = {err_next[W-1], err_next} - {previous_error[W-1], previous_error};
    der_next = sat_w1(der_wide);
  end

  // throttle accumulate; terms are floor-scaled by the dropped fraction bits
  always_comb begin
    acc = AW'(throttle_level)
        - AW'($signed(prod_p[PW-1:apt_pkg::FracW]))
        - AW'($signed(prod_i[PW-1:apt_pkg::FracW]))
        - AW'($signed(prod_d[PW-1:apt_pkg::FracW]));
    if (acc > AW'(throttle_sat_max())) begin
      throttle_next = {1'b0, {(W-1){1'b1}}};
    end else if (acc < AW'(throttle_sat_min())) begin
      throttle_next = {1'b1, {(W-1){1'b0}}};
    end else begin
      throttle_next = acc[W-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_altitude <= '0;
      p_gain          <= '0;
      i_gain          <= '0;
      d_gain          <= '0;
      integral_limit  <= '0;
    end else if (write_enable) begin
      case (reg_index)
        apt_pkg::REG_TARGET: target_altitude <= write_data;
        apt_pkg::REG_PGAIN:  p_gain          <= write_data;
        apt_pkg::REG_IGAIN:  i_gain          <= write_data;
        apt_pkg::REG_DGAIN:  d_gain          <= write_data;
        apt_pkg::REG_LIMIT:  integral_limit  <= write_data[apt_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      va             <= 1'b0;
      vb             <= 1'b0;
      vo             <= 1'b0;
      err_accum      <= '0;
      previous_error <= '0;
      throttle_level <= apt_pkg::ThrottleReset;
    end else begin
      if (accept) begin
        va             <= 1'b1;
        err_accum      <= sum_next;
        previous_error <= err_next;
      end else if (adv_b) begin
        va <= 1'b0;
      end
      if (adv_b) begin
        vb <= 1'b1;
      end else if (adv_o) begin
        vb <= 1'b0;
      end
      if (adv_o) begin
        vo             <= 1'b1;
        throttle_level <= throttle_next;
      end else if (result.ready) begin
        vo <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      err_a <= err_next;
      sum_a <= sum_next;
      der_a <= der_next;
    end
    if (adv_b) begin
      prod_p <= PW'(p_gain) * PW'(err_a);
      prod_i <= PW'(i_gain) * PW'(sum_a);
      prod_d <= PW'(d_gain) * PW'(der_a);
    end
  end

  `APT_ASSERT_NEXT(a_accept_fills_a, accept, va, "accepted sample not held in stage A")
  `APT_ASSERT_NEXT(a_prev_err_tracks, accept, previous_error == err_a,
    "previous error not stored from accepted sample")
  `APT_ASSERT_NEXT(a_adv_fills_out, adv_o, vo, "result register not loaded")
  `APT_ASSERT_SAME(a_no_overrun, va && vb && vo && !result.ready, !sample.ready,
    "sample taken while pipeline full and stalled")

endmodule
